// File: design/eegp_pkg.sv
package eegp_pkg;

  localparam logic [7:0] SyncByte       = 8'hAA;
  localparam logic [7:0] CodeQuality    = 8'h02;
  localparam logic [7:0] CodeAttention  = 8'h04;
  localparam logic [7:0] CodeMeditation = 8'h05;
  localparam logic [7:0] CodePower      = 8'h83;
  localparam logic [7:0] PowerBytes     = 8'd24;
  localparam logic [7:0] MaxLenReset    = 8'd169;
  localparam int unsigned LevelCount    = 3;
  localparam int unsigned BandCount     = 8;

  // Index of each one-byte level in the value set
  localparam int unsigned LvlQuality    = 0;
  localparam int unsigned LvlAttention  = 1;
  localparam int unsigned LvlMeditation = 2;

  typedef struct packed {
    logic [LevelCount-1:0][7:0] level;
    logic [BandCount-1:0][23:0] band;
    logic                       seen;
  } eegp_vals_t;

  typedef struct packed {
    logic       payload;
    logic       start;
    logic       commit;
    logic [7:0] left_after;
  } eegp_ctrl_t;

endpackage

// File: design/eegp_frame_fsm.sv
module eegp_frame_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic [7:0]          max_len_i,
  output eegp_pkg::eegp_ctrl_t ctrl_o
);
  import eegp_pkg::*;

  typedef enum logic [2:0] {
    Sync1,
    Sync2,
    Length,
    Payload,
    Check
  } phase_e;

  phase_e     phase_q;
  logic [7:0] len_q;
  logic [7:0] taken_q;
  logic [7:0] sum_q;
  logic [7:0] taken_inc;

  assign taken_inc = taken_q + 8'd1;

  always_comb begin
    ctrl_o            = '0;
    ctrl_o.payload    = step_i && (phase_q == Payload);
    ctrl_o.start      = step_i && (phase_q == Length) && (byte_i <= max_len_i);
    ctrl_o.commit     = step_i && (phase_q == Check) && (byte_i == ~sum_q);
    ctrl_o.left_after = len_q - taken_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= Sync1;
      len_q   <= '0;
      taken_q <= '0;
      sum_q   <= '0;
    end else if (step_i) begin
      case (phase_q)
        Sync1: begin
          if (byte_i == SyncByte) phase_q <= Sync2;
        end
        Sync2: begin
          phase_q <= (byte_i == SyncByte) ? Length : Sync1;
        end
        Length: begin
          if (byte_i > max_len_i) begin
            phase_q <= Sync1;
          end else begin
            len_q   <= byte_i;
            taken_q <= '0;
            sum_q   <= '0;
            phase_q <= (byte_i == 8'd0) ? Check : Payload;
          end
        end
        Payload: begin
          sum_q   <= sum_q + byte_i;
          taken_q <= taken_inc;
          if (taken_inc >= len_q) phase_q <= Check;
        end
        Check: begin
          phase_q <= Sync1;
        end
        default: begin
          phase_q <= Sync1;
        end
      endcase
    end
  end

endmodule

// File: design/eegp_row_parser.sv
module eegp_row_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  eegp_pkg::eegp_ctrl_t ctrl_i,
  input  logic [7:0]           byte_i,
  input  eegp_pkg::eegp_vals_t committed_i,
  output eegp_pkg::eegp_vals_t shadow_o
);
  import eegp_pkg::*;

  typedef enum logic [2:0] {
    RowCode,
    RowValue,
    RowVlen,
    RowSkip,
    RowPower
  } row_e;

  row_e       row_q;
  logic [7:0] code_q;
  logic [7:0] remain_q;
  logic [3:0] band_q;    // band being filled; bit 3 set once all 24 bytes are in
  logic [1:0] pos_q;     // byte within the band, most significant first
  eegp_vals_t shadow_q;

  assign shadow_o = shadow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= RowCode;
      code_q   <= '0;
      remain_q <= '0;
      band_q   <= '0;
      pos_q    <= '0;
      shadow_q <= '0;
    end else if (ctrl_i.start) begin
      // each frame works on a fresh copy of the committed values
      row_q    <= RowCode;
      code_q   <= '0;
      remain_q <= '0;
      shadow_q <= committed_i;
    end else if (ctrl_i.payload) begin
      case (row_q)
        RowCode: begin
          code_q <= byte_i;
          row_q  <= byte_i[7] ? RowVlen : RowValue;
        end
        RowValue: begin
          if (code_q == CodeQuality) shadow_q.level[LvlQuality] <= byte_i;
          else if (code_q == CodeAttention) shadow_q.level[LvlAttention] <= byte_i;
          else if (code_q == CodeMeditation) shadow_q.level[LvlMeditation] <= byte_i;
          row_q <= RowCode;
        end
        RowVlen: begin
          remain_q <= byte_i;
          band_q   <= '0;
          pos_q    <= '0;
          if (byte_i == 8'd0) begin
            row_q <= RowCode;
          end else if (code_q == CodePower && byte_i >= PowerBytes &&
                       byte_i <= ctrl_i.left_after) begin
            shadow_q.seen <= 1'b1;
            row_q         <= RowPower;
          end else begin
            row_q <= RowSkip;
          end
        end
        RowPower: begin
          if (!band_q[3]) begin
            case (pos_q)
              2'd0:    shadow_q.band[band_q[2:0]][23:16] <= byte_i;
              2'd1:    shadow_q.band[band_q[2:0]][15:8]  <= byte_i;
              default: shadow_q.band[band_q[2:0]][7:0]   <= byte_i;
            endcase
            if (pos_q == 2'd2) begin
              pos_q  <= '0;
              band_q <= band_q + 4'd1;
            end else begin
              pos_q <= pos_q + 2'd1;
            end
          end
          remain_q <= remain_q - 8'd1;
          if (remain_q == 8'd1) row_q <= RowCode;
        end
        RowSkip: begin
          remain_q <= remain_q - 8'd1;
          if (remain_q == 8'd1) row_q <= RowCode;
        end
        default: begin
          row_q <= RowCode;
        end
      endcase
    end
  end

endmodule

// File: design/eeg_packet_stream_parser_core.sv
// out_valid_o is registered; it rises once the held checksum byte is processed and equals the inverted payload sum.
// Throughput: one byte per cycle; the input register drains whenever the
// result register is empty or being taken, so a byte is taken every cycle
// unless a result is left waiting while the next byte is already held.
// Reset (rst_ni low, asynchronous): sync search restarts, all values clear,
// the length limit returns to 169.
module eeg_packet_stream_parser_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [7:0]   data_byte_i,
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_wdata_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [7:0]   signal_quality_o,
  output logic [7:0]   attention_o,
  output logic [7:0]   meditation_o,
  output logic [23:0]  delta_power_o,
  output logic [23:0]  theta_power_o,
  output logic [23:0]  low_alpha_power_o,
  output logic [23:0]  high_alpha_power_o,
  output logic [23:0]  low_beta_power_o,
  output logic [23:0]  high_beta_power_o,
  output logic [23:0]  low_gamma_power_o,
  output logic [23:0]  mid_gamma_power_o,
  output logic         power_seen_o
);
  import eegp_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic [7:0] max_len_q;
  logic       out_valid_q, out_valid_d;
  logic       step;
  eegp_ctrl_t ctrl;
  eegp_vals_t shadow;
  eegp_vals_t committed_q;

  // process the held byte only when the result register can take a result
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) in_valid_d = 1'b1;
    else if (step)                in_valid_d = 1'b0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.commit)      out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      max_len_q   <= MaxLenReset;
      committed_q <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i)    max_len_q   <= cfg_wdata_i;
      // committed values double as the result register
      if (ctrl.commit) committed_q <= shadow;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_byte_q <= data_byte_i;
  end

  eegp_frame_fsm u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (in_byte_q),
    .max_len_i (max_len_q),
    .ctrl_o    (ctrl)
  );

  eegp_row_parser u_rows (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .byte_i      (in_byte_q),
    .committed_i (committed_q),
    .shadow_o    (shadow)
  );

  assign out_valid_o        = out_valid_q;
  assign signal_quality_o   = committed_q.level[LvlQuality];
  assign attention_o        = committed_q.level[LvlAttention];
  assign meditation_o       = committed_q.level[LvlMeditation];
  assign delta_power_o      = committed_q.band[0];
  assign theta_power_o      = committed_q.band[1];
  assign low_alpha_power_o  = committed_q.band[2];
  assign high_alpha_power_o = committed_q.band[3];
  assign low_beta_power_o   = committed_q.band[4];
  assign high_beta_power_o  = committed_q.band[5];
  assign low_gamma_power_o  = committed_q.band[6];
  assign mid_gamma_power_o  = committed_q.band[7];
  assign power_seen_o       = committed_q.seen;

endmodule

// File: design/eegp_checker.sv
module eegp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  attention_o,
  input logic [23:0] delta_power_o,
  input logic        power_seen_o
);

  // with the result register empty the held byte always drains
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no result pending");

  // once a band power row is committed the flag never clears
  a_seen_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(power_seen_o))
    else $error("power_seen dropped");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(attention_o) && $stable(delta_power_o))
    else $error("result changed while stalled");

endmodule

bind eeg_packet_stream_parser_core eegp_checker u_eegp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .attention_o   (attention_o),
  .delta_power_o (delta_power_o),
  .power_seen_o  (power_seen_o)
);
